// File: rtl/chme_pkg.sv
// ----------------------------------------------------------------------------
// chme_pkg
// Shared constants and codes of the chained hash map engine.
// ----------------------------------------------------------------------------
package chme_pkg;

	localparam int BUCKETS_DEF = 256;
	localparam int CELLS_DEF   = 1024;

	localparam int KEY_W    = 32;
	localparam int VAL_W    = 32;
	localparam int CAP_W    = 11;
	localparam int STATUS_W = 3;

	typedef enum logic [1:0] {
		CMD_GET    = 2'd0,
		CMD_ADD    = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_NOT_FOUND = 3'd1,
		ST_PRESENT   = 3'd2,
		ST_FULL      = 3'd3,
		ST_ZERO_DATA = 3'd4
	} status_t;

	typedef enum logic [0:0] {
		REG_KEY_CAPACITY = 1'd0,
		REG_GROW_ALLOWED = 1'd1
	} reg_idx_t;

endpackage

// File: rtl/chme_bucket_mod.sv
// ----------------------------------------------------------------------------
// chme_bucket_mod
// Key modulo bucket count: a mask for a power of two, else a radix-16
// remainder with parallel compare and subtract over the eight key digits.
// ----------------------------------------------------------------------------
module chme_bucket_mod
	import chme_pkg::*;
#(
	parameter int BUCKETS = BUCKETS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [KEY_W-1:0]           key,
	output logic                       done,
	output logic [$clog2(BUCKETS)-1:0] rem
);

	localparam int BW    = $clog2(BUCKETS);
	localparam int DIG_W = 4;
	localparam int NDIG  = KEY_W / DIG_W;
	localparam int CNT_W = $clog2(NDIG);
	localparam int TW    = BW + DIG_W;

	generate
		if ((BUCKETS & (BUCKETS - 1)) == 0) begin : g_pow2
			logic          done_q;
			logic [BW-1:0] rem_q;

			// remainder is the low key bits
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else begin
					done_q <= start;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					rem_q <= key[BW-1:0];
				end
			end

			assign done = done_q;
			assign rem  = rem_q;
		end else begin : g_digit
			logic             busy_q;
			logic             done_q;
			logic [CNT_W-1:0] cnt_q;
			logic [KEY_W-1:0] key_q;
			logic [BW-1:0]    rem_q;
			logic [TW-1:0]    trial;
			logic [TW-1:0]    sub;
			logic [TW-1:0]    reduced;

			// shift in one key digit, subtract the largest multiple of the modulus
			// that fits; all multiples are compared side by side
			always_comb begin
				trial = {rem_q, key_q[KEY_W-1 -: DIG_W]};
				sub   = '0;
				for (int k = 1; k < (1 << DIG_W); k++) begin
					if (trial >= TW'(k * BUCKETS)) begin
						sub = TW'(k * BUCKETS);
					end
				end
				reduced = trial - sub;
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					busy_q <= 1'b0;
					done_q <= 1'b0;
					cnt_q  <= '0;
				end else begin
					done_q <= 1'b0;
					if (start) begin
						busy_q <= 1'b1;
						cnt_q  <= '0;
					end else if (busy_q) begin
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == CNT_W'(NDIG - 1)) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
						end
					end
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					key_q <= key;
					rem_q <= '0;
				end else if (busy_q) begin
					key_q <= {key_q[KEY_W-DIG_W-1:0], {DIG_W{1'b0}}};
					rem_q <= reduced[BW-1:0];
				end
			end

			assign done = done_q;
			assign rem  = rem_q;
		end
	endgenerate

endmodule

// File: rtl/chained_hash_map_engine.sv
// ----------------------------------------------------------------------------
// chained_hash_map_engine
// Key to data map with separate chaining over a cell pool in block memory.
// ----------------------------------------------------------------------------
// sequence: clear and zero-data add finish without a walk; get/add/remove read
//   the bucket head and walk the chain cell by cell, with a miss state, a write
//   state on a successful add or remove, and a digit-serial remainder when the bucket count is not a power of two
// throughput: one item at a time; input ready again as the result item is offered
// reset: bucket valid bits clear at once; the pool starts lazily from a fill
//   count, so neither reset nor clear needs a clearing pass
module chained_hash_map_engine
	import chme_pkg::*;
#(
	parameter int BUCKETS = BUCKETS_DEF,
	parameter int CELLS   = CELLS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,   // command[1:0], key[33:2], value_in[65:34]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // status[2:0], value_out[34:3]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int BW  = $clog2(BUCKETS);
	localparam int CW  = $clog2(CELLS);
	localparam int NW  = $clog2(CELLS + 1);
	localparam int LW  = (NW > CAP_W) ? NW : CAP_W;
	// cell word: link, link valid, value, key
	localparam int LV_B  = CW;
	localparam int VAL_L = CW + 1;
	localparam int KEY_L = VAL_L + VAL_W;
	localparam int WW    = KEY_L + KEY_W;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_MOD   = 8'b0000_0010,
		S_BREAD = 8'b0000_0100,
		S_HEAD  = 8'b0000_1000,
		S_WALK  = 8'b0001_0000,
		S_MISS  = 8'b0010_0000,
		S_ALLOC = 8'b0100_0000,
		S_FREE  = 8'b1000_0000
	} state_t;

	state_t state_q;
	logic   done_q;

	// registers
	logic [CAP_W-1:0] key_cap_q;
	logic             grow_q;

	// item
	cmd_t             cmd_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;

	// pool control
	logic [BUCKETS-1:0] bvalid_q;
	logic [CW-1:0]      free_head_q;
	logic [NW-1:0]      in_use_q;
	logic [NW-1:0]      fresh_q;

	// walk
	logic [BW-1:0] b_q;
	logic [CW-1:0] cur_q;
	logic [CW-1:0] prev_q;
	logic [WW-1:0] prevw_q;
	logic          has_prev_q;
	logic [WW-1:0] hitw_q;

	// result
	logic                res_ld;
	status_t             res_st;
	logic [VAL_W-1:0]    res_val;
	logic                m_valid_q;
	logic [STATUS_W-1:0] m_st_q;
	logic [VAL_W-1:0]    m_val_q;
	logic [STATUS_W-1:0] o_st_q;
	logic [VAL_W-1:0]    o_val_q;

	// memories
	logic [CW-1:0] bmem [BUCKETS];
	logic [CW-1:0] b_rd;
	logic          b_we;
	logic [CW-1:0] b_wdata;
	logic [WW-1:0] cmem [CELLS];
	logic [WW-1:0] c_rd;
	logic [CW-1:0] c_raddr;
	logic          c_we;
	logic [CW-1:0] c_waddr;
	logic [WW-1:0] c_wdata;

	// remainder unit
	logic          start_q;
	logic          m_done;
	logic [BW-1:0] m_rem;

	logic          in_acc;
	logic          key_hit;
	logic          full;
	logic [LW-1:0] limit;
	logic [CW-1:0] next_free;

	chme_bucket_mod #(.BUCKETS(BUCKETS)) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.key    (key_q),
		.done   (m_done),
		.rem    (m_rem)
	);

	assign s_axis_tready = (state_q == S_IDLE) && !done_q;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_cap_q <= CAP_W'(1024);
			grow_q    <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_KEY_CAPACITY: key_cap_q <= cfg_data[CAP_W-1:0];
				REG_GROW_ALLOWED: grow_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// capacity check
	always_comb begin
		if (grow_q || (LW'(key_cap_q) >= LW'(CELLS))) begin
			limit = LW'(CELLS);
		end else begin
			limit = LW'(key_cap_q);
		end
		full = LW'(in_use_q) >= limit;
	end

	// free list successor; cells beyond the fill count still chain to the next one
	always_comb begin
		if (NW'(free_head_q) < fresh_q) begin
			next_free = c_rd[CW-1:0];
		end else if (free_head_q == CW'(CELLS - 1)) begin
			next_free = '0;
		end else begin
			next_free = free_head_q + 1'b1;
		end
	end

	assign key_hit = (c_rd[KEY_L +: KEY_W] == key_q);

	// memory access and result control
	always_comb begin
		b_we    = 1'b0;
		b_wdata = c_rd[CW-1:0];
		c_we    = 1'b0;
		c_waddr = cur_q;
		c_wdata = c_rd;
		c_raddr = cur_q;
		res_ld  = 1'b0;
		res_st  = ST_OK;
		res_val = '0;
		case (state_q)
			S_IDLE: begin
			end
			S_MOD: begin
			end
			S_BREAD: begin
			end
			S_HEAD: begin
				c_raddr = b_rd;
			end
			S_WALK: begin
				c_raddr = c_rd[CW-1:0];
				if (key_hit) begin
					case (cmd_q)
						CMD_GET: begin
							res_ld  = 1'b1;
							res_val = c_rd[VAL_L +: VAL_W];
						end
						CMD_ADD: begin
							res_ld = 1'b1;
							res_st = ST_PRESENT;
						end
						default: begin
							// unlink from the predecessor or the bucket head
							if (has_prev_q) begin
								c_we    = 1'b1;
								c_waddr = prev_q;
								c_wdata = {prevw_q[WW-1:CW+1], c_rd[CW:0]};
							end else begin
								b_we = 1'b1;
							end
						end
					endcase
				end else if (!c_rd[LV_B]) begin
					c_raddr = free_head_q;
				end
			end
			S_MISS: begin
				c_raddr = free_head_q;
				if (cmd_q != CMD_ADD) begin
					res_ld = 1'b1;
					res_st = ST_NOT_FOUND;
				end else if (full) begin
					res_ld = 1'b1;
					res_st = ST_FULL;
				end
			end
			S_ALLOC: begin
				c_we    = 1'b1;
				c_waddr = free_head_q;
				c_wdata = {key_q, val_q, bvalid_q[b_q], b_rd};
				b_we    = 1'b1;
				b_wdata = free_head_q;
				res_ld  = 1'b1;
			end
			S_FREE: begin
				c_we    = 1'b1;
				c_waddr = cur_q;
				c_wdata = {hitw_q[WW-1:CW+1], 1'b0, free_head_q};
				res_ld  = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// bucket head memory
	always_ff @(posedge clk) begin
		if (b_we) begin
			bmem[b_q] <= b_wdata;
		end
		b_rd <= bmem[b_q];
	end

	// cell memory
	always_ff @(posedge clk) begin
		if (c_we) begin
			cmem[c_waddr] <= c_wdata;
		end
		c_rd <= cmem[c_raddr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			done_q      <= 1'b0;
			bvalid_q    <= '0;
			free_head_q <= '0;
			in_use_q    <= '0;
			fresh_q     <= '0;
			has_prev_q  <= 1'b0;
			m_valid_q   <= 1'b0;
			b_q         <= '0;
			cur_q       <= '0;
			prev_q      <= '0;
			prevw_q     <= '0;
			hitw_q      <= '0;
		end else begin
			if (done_q && (!m_valid_q || m_axis_tready)) begin
				m_valid_q <= 1'b1;
				done_q    <= 1'b0;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			if (res_ld) begin
				done_q  <= 1'b1;
				state_q <= S_IDLE;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (cmd_t'(s_axis_tdata[1:0]) == CMD_CLEAR) begin
							bvalid_q    <= '0;
							free_head_q <= '0;
							in_use_q    <= '0;
							fresh_q     <= '0;
							done_q      <= 1'b1;
						end else if (cmd_t'(s_axis_tdata[1:0]) == CMD_ADD &&
								s_axis_tdata[65:34] == '0) begin
							done_q <= 1'b1;
						end else begin
							state_q <= S_MOD;
						end
					end
				end
				S_MOD: begin
					has_prev_q <= 1'b0;
					if (m_done) begin
						b_q     <= m_rem;
						state_q <= S_BREAD;
					end
				end
				S_BREAD: begin
					state_q <= S_HEAD;
				end
				S_HEAD: begin
					cur_q   <= b_rd;
					state_q <= bvalid_q[b_q] ? S_WALK : S_MISS;
				end
				S_WALK: begin
					if (key_hit) begin
						if (cmd_q == CMD_REMOVE) begin
							hitw_q  <= c_rd;
							state_q <= S_FREE;
							if (!has_prev_q) begin
								bvalid_q[b_q] <= c_rd[LV_B];
							end
						end
					end else if (c_rd[LV_B]) begin
						prev_q     <= cur_q;
						prevw_q    <= c_rd;
						has_prev_q <= 1'b1;
						cur_q      <= c_rd[CW-1:0];
					end else begin
						state_q <= S_MISS;
					end
				end
				S_MISS: begin
					if (!res_ld) begin
						state_q <= S_ALLOC;
					end
				end
				S_ALLOC: begin
					free_head_q   <= next_free;
					bvalid_q[b_q] <= 1'b1;
					in_use_q      <= in_use_q + 1'b1;
					if (NW'(free_head_q) == fresh_q) begin
						fresh_q <= fresh_q + 1'b1;
					end
				end
				S_FREE: begin
					free_head_q <= cur_q;
					if (in_use_q != '0) begin
						in_use_q <= in_use_q - 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item capture and result registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q <= cmd_t'(s_axis_tdata[1:0]);
			key_q <= s_axis_tdata[33:2];
			val_q <= s_axis_tdata[65:34];
			// clear and zero-data add finish at once
			m_st_q  <= (cmd_t'(s_axis_tdata[1:0]) == CMD_ADD) ? ST_ZERO_DATA : ST_OK;
			m_val_q <= '0;
		end
		if (res_ld) begin
			m_st_q  <= res_st;
			m_val_q <= res_val;
		end
	end

	// the remainder unit starts in the cycle after the item is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b0;
		end else begin
			start_q <= in_acc && (cmd_t'(s_axis_tdata[1:0]) != CMD_CLEAR) &&
				!(cmd_t'(s_axis_tdata[1:0]) == CMD_ADD && s_axis_tdata[65:34] == '0);
		end
	end

	// output register, loaded from the held result when the slot frees
	always_ff @(posedge clk) begin
		if (done_q && (!m_valid_q || m_axis_tready)) begin
			o_st_q  <= m_st_q;
			o_val_q <= m_val_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {5'b0, o_val_q, o_st_q};

endmodule

// File: test/tb_chained_hash_map_engine.sv
// ----------------------------------------------------------------------------
// tb_chained_hash_map_engine
// Self-checking regression of the chained hash map engine: a queue-fed driver
// sends get, add, remove and clear items with random gaps, a scoreboard of
// predicted results is kept by a behavioral copy of the map, and a monitor
// with random back-pressure checks every result.
// ----------------------------------------------------------------------------
module tb_chained_hash_map_engine;
	import chme_pkg::*;

	localparam int NB        = BUCKETS_DEF;
	localparam int NC        = CELLS_DEF;
	localparam int MAX_CYC   = 3000000;
	localparam int SETTLE    = 1200;

	typedef struct packed {
		cmd_t        cmd;
		logic [31:0] key;
		logic [31:0] val;
	} map_op_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] val;
	} map_resp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata = '0;   // command[1:0], key[33:2], value_in[65:34]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;        // status[2:0], value_out[34:3]
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [0:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	chained_hash_map_engine uut (.*);

	always #6 clk = ~clk;

	// shadow map state
	logic [10:0] head_cell [NB];
	bit          head_ok [NB];
	logic [31:0] cell_k [NC];
	logic [31:0] cell_v [NC];
	logic [10:0] next_cell [NC];
	bit          next_ok [NC];
	int unsigned free_cell;
	int unsigned used_cells;
	int unsigned cap_reg = 1024;
	bit          grow_reg = 1'b1;

	map_op_t   op_queue [$];
	map_resp_t resp_queue [$];
	int        errors = 0;
	int        cycles = 0;
	bit        sent_flag = 0;
	bit        got_flag = 0;
	int        gap_left = 0;
	int        stall_left = 0;
	bit        calm = 0;

	function automatic void map_empty();
		for (int i = 0; i < NB; i++) begin
			head_cell[i] = '0;
			head_ok[i] = 0;
		end
		for (int i = 0; i < NC; i++) begin
			next_cell[i] = (i + 1 < NC) ? 11'(i + 1) : 11'd0;
			next_ok[i] = 0;
		end
		free_cell = 0;
		used_cells = 0;
	endfunction

	// chain walk: hit cell, its predecessor and whether it has one
	function automatic bit chain_lookup(int unsigned b, logic [31:0] k, output int unsigned hit,
			output int unsigned prev, output bit has_prev);
		int unsigned c;
		bit ok;
		int unsigned steps;
		c = head_cell[b];
		ok = head_ok[b];
		prev = 0;
		has_prev = 0;
		hit = 0;
		steps = 0;
		while (ok && c < NC && steps < NC) begin
			if (cell_k[c] == k) begin
				hit = c;
				return 1;
			end
			prev = c;
			has_prev = 1;
			ok = next_ok[c];
			c = next_cell[c];
			steps++;
		end
		return 0;
	endfunction

	function automatic map_resp_t map_apply(map_op_t op);
		map_resp_t r;
		int unsigned b, hit, prev, lim, c;
		bit hp;
		r.status = ST_OK;
		r.val = '0;
		b = op.key % NB;
		lim = grow_reg ? NC : ((cap_reg < NC) ? cap_reg : NC);
		case (op.cmd)
			CMD_GET: begin
				if (chain_lookup(b, op.key, hit, prev, hp)) r.val = cell_v[hit];
				else r.status = ST_NOT_FOUND;
			end
			CMD_ADD: begin
				if (op.val == 0) r.status = ST_ZERO_DATA;
				else if (chain_lookup(b, op.key, hit, prev, hp)) r.status = ST_PRESENT;
				else if (used_cells >= lim || free_cell >= NC) r.status = ST_FULL;
				else begin
					c = free_cell;
					free_cell = next_cell[c];
					cell_k[c] = op.key;
					cell_v[c] = op.val;
					next_cell[c] = head_cell[b];
					next_ok[c] = head_ok[b];
					head_cell[b] = 11'(c);
					head_ok[b] = 1;
					used_cells++;
				end
			end
			CMD_REMOVE: begin
				if (chain_lookup(b, op.key, hit, prev, hp)) begin
					if (hp) begin
						next_cell[prev] = next_cell[hit];
						next_ok[prev] = next_ok[hit];
					end else begin
						head_cell[b] = next_cell[hit];
						head_ok[b] = next_ok[hit];
					end
					next_cell[hit] = 11'(free_cell);
					next_ok[hit] = 0;
					free_cell = hit;
					if (used_cells > 0) used_cells--;
				end else r.status = ST_NOT_FOUND;
			end
			default: map_empty();
		endcase
		return r;
	endfunction

	// accept items, predict, check results, watch the cycle limit
	always @(posedge clk) begin
		map_resp_t want;
		if (arst_n) begin
			cycles++;
			if (cycles > MAX_CYC) begin
				$display("chained_hash_map_engine regression: fail");
				$finish;
			end else begin
				if (s_axis_tvalid && s_axis_tready) begin
					resp_queue.push_back(map_apply(map_op_t'({cmd_t'(s_axis_tdata[1:0]),
						s_axis_tdata[33:2], s_axis_tdata[65:34]})));
					sent_flag = 1;
				end
				if (m_axis_tvalid && m_axis_tready) begin
					got_flag = 1;
					if (resp_queue.size() == 0) begin
						errors++;
						if (errors <= 10) $display("unexpected result item %h", m_axis_tdata);
					end else begin
						want = resp_queue.pop_front();
						if (m_axis_tdata[2:0] !== want.status ||
								m_axis_tdata[34:3] !== want.val) begin
							errors++;
							if (errors <= 10)
								$display("mismatch: status exp %0d got %0d, value exp %h got %h",
									want.status, m_axis_tdata[2:0], want.val, m_axis_tdata[34:3]);
						end
					end
				end
			end
		end
	end

	// item driver with random gaps
	always @(negedge clk) begin
		map_op_t op;
		bit v;
		v = s_axis_tvalid;
		if (sent_flag) begin
			sent_flag = 0;
			v = 0;
			gap_left = calm ? 0 : $urandom_range(0, 19);
		end
		if (arst_n && !v) begin
			if (gap_left > 0) gap_left--;
			else if (op_queue.size() > 0) begin
				op = op_queue.pop_front();
				s_axis_tdata <= {6'b0, op.val, op.key, op.cmd};
				v = 1;
			end
		end
		s_axis_tvalid <= v;
	end

	// result back-pressure
	always @(negedge clk) begin
		if (got_flag) begin
			got_flag = 0;
			stall_left = calm ? 0 : $urandom_range(0, 19);
		end
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else m_axis_tready <= arst_n;
	end

	task automatic push_op(cmd_t c, logic [31:0] k, logic [31:0] v);
		op_queue.push_back('{c, k, v});
	endtask

	// wait until every result is back, then let the engine settle
	task automatic drain();
		do @(posedge clk);
		while (op_queue.size() > 0 || s_axis_tvalid || resp_queue.size() > 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic reg_write(reg_idx_t idx, logic [31:0] d);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk);
		while (!cfg_ready);
		if (idx == REG_KEY_CAPACITY) cap_reg = d[10:0];
		else grow_reg = d[0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// keys crowd a few buckets so chains grow and collide
	function automatic logic [31:0] pick_key();
		if ($urandom_range(0, 9) == 0) return $urandom;
		return 32'($urandom_range(0, 15)) * NB + 32'($urandom_range(0, 3)) + 32'd252;
	endfunction

	task automatic random_ops(int n);
		int r;
		cmd_t c;
		logic [31:0] v;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			c = (r < 40) ? CMD_ADD : (r < 70) ? CMD_GET : (r < 98) ? CMD_REMOVE : CMD_CLEAR;
			v = ($urandom_range(0, 19) == 0) ? 32'd0 : $urandom;
			push_op(c, pick_key(), v);
		end
	endtask

	initial begin
		int caps [7] = '{1024, 7, 0, 2047, 40, 1, 300};
		bit grows [7] = '{1, 0, 0, 0, 0, 0, 1};
		for (int i = 0; i < NC; i++) begin
			cell_k[i] = '0;
			cell_v[i] = '0;
		end
		map_empty();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, collisions, absent keys, clear
		push_op(CMD_GET, 32'd0, 32'd0);
		push_op(CMD_ADD, 32'd0, 32'd0);
		push_op(CMD_ADD, 32'd0, 32'hFFFF_FFFF);
		push_op(CMD_ADD, 32'd0, 32'd5);
		push_op(CMD_ADD, 32'd256, 32'd1);
		push_op(CMD_ADD, 32'hFFFF_FFFF, 32'h8000_0001);
		push_op(CMD_GET, 32'd0, 32'd0);
		push_op(CMD_GET, 32'd256, 32'd0);
		push_op(CMD_GET, 32'hFFFF_FFFF, 32'd0);
		push_op(CMD_GET, 32'd512, 32'd0);
		push_op(CMD_REMOVE, 32'd512, 32'd0);
		push_op(CMD_REMOVE, 32'd0, 32'd0);
		push_op(CMD_GET, 32'd0, 32'd0);
		push_op(CMD_REMOVE, 32'd256, 32'd0);
		push_op(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_op(CMD_GET, 32'hFFFF_FFFF, 32'd0);
		drain();

		// capacity cap of two without growth
		reg_write(REG_KEY_CAPACITY, 32'd2);
		reg_write(REG_GROW_ALLOWED, 32'd0);
		push_op(CMD_ADD, 32'd10, 32'd1);
		push_op(CMD_ADD, 32'd11, 32'd2);
		push_op(CMD_ADD, 32'd12, 32'd3);
		push_op(CMD_ADD, 32'd13, 32'd0);
		push_op(CMD_ADD, 32'd10, 32'd4);
		drain();
		reg_write(REG_KEY_CAPACITY, 32'd0);
		push_op(CMD_ADD, 32'd14, 32'd9);
		push_op(CMD_CLEAR, 32'd0, 32'd0);
		drain();

		// random phases over several register settings
		for (int p = 0; p < 7; p++) begin
			reg_write(REG_KEY_CAPACITY, 32'(caps[p]));
			reg_write(REG_GROW_ALLOWED, 32'(grows[p]));
			for (int s = 0; s < 4; s++) begin
				calm = ($urandom_range(0, 3) == 0);
				random_ops(27);
				if (s == 1) begin
					do @(posedge clk);
					while (op_queue.size() > 0 || s_axis_tvalid || resp_queue.size() > 0);
				end
			end
			drain();
		end

		if (errors == 0) $display("chained_hash_map_engine regression: pass");
		else $display("chained_hash_map_engine regression: fail");
		$finish;
	end

endmodule
